// ===== design/utf8s_pkg.sv =====
// shared types, constants and the code point filter of the utf-8 text sanitizer
package utf8s_pkg;

	// longest run of output bytes that one input byte can cause
	localparam int unsigned MAX_RUN = 3;

	// queue between the decoder and the serializer
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [20:0] CP_REPLACE = 21'h00FFFD;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_QUEST  = 8'h3F;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] cnt_t;

	// output bytes of one input byte, first byte in data[0]
	typedef struct packed {
		byte_t [MAX_RUN-1:0] data;
		cnt_t                cnt;
		logic                last;
	} plan_t;

	// bytes that one code point turns into
	typedef struct packed {
		byte_t [MAX_RUN-1:0] data;
		cnt_t                cnt;
	} filt_t;

	// decoder to queue
	typedef struct packed {
		logic  push;
		plan_t plan;
	} qwr_t;

	// queue head to serializer
	typedef struct packed {
		logic  avail;
		plan_t plan;
	} qrd_t;

	// one result on the output channel
	typedef struct packed {
		byte_t out_byte;
		logic  byte_valid;
		logic  run_last;
		logic  text_end;
	} res_t;

	// classify a code point and give its replacement or re-encoded bytes
	function automatic filt_t filter_cp(input logic [20:0] cp);
		logic  kept;
		logic  spc;
		logic  hyp;
		logic  drop;
		filt_t r;
		kept = (cp == 21'h0A) || (cp >= 21'h20 && cp < 21'h7F) ||
			(cp >= 21'hA0 && cp <= 21'hFF) || (cp == 21'h2013) || (cp == 21'h2014) ||
			(cp >= 21'h2018 && cp <= 21'h201E) || (cp == 21'h2022) ||
			(cp == 21'h2026) || (cp == 21'h20AC);
		spc = (cp == 21'h09) || (cp == 21'h2002) || (cp == 21'h2003) ||
			(cp == 21'h2009) || (cp == 21'h202F);
		hyp = (cp == 21'h2010) || (cp == 21'h2011) || (cp == 21'h2212);
		drop = (cp < 21'h20) || (cp >= 21'h7F && cp < 21'hA0) ||
			(cp >= 21'h200B && cp <= 21'h200D) || (cp >= 21'hFE00 && cp <= 21'hFE0F) ||
			(cp >= 21'h2600 && cp <= 21'h27BF) || (cp >= 21'h1F000);
		r.data = '0;
		r.cnt  = 2'd0;
		if (kept) begin
			if (cp < 21'h80) begin
				r.data[0] = cp[7:0];
				r.cnt     = 2'd1;
			end else if (cp < 21'h800) begin
				r.data[0] = {3'b110, cp[10:6]};
				r.data[1] = {2'b10, cp[5:0]};
				r.cnt     = 2'd2;
			end else begin
				r.data[0] = {4'b1110, cp[15:12]};
				r.data[1] = {2'b10, cp[11:6]};
				r.data[2] = {2'b10, cp[5:0]};
				r.cnt     = 2'd3;
			end
		end else if (spc) begin
			r.data[0] = CH_SPACE;
			r.cnt     = 2'd1;
		end else if (hyp) begin
			r.data[0] = CH_HYPHEN;
			r.cnt     = 2'd1;
		end else if (!drop) begin
			r.data[0] = CH_QUEST;
			r.cnt     = 2'd1;
		end
		return r;
	endfunction

endpackage

// ===== design/utf8s_in_if.sv =====
// input channel: one raw text byte per transfer
interface utf8s_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source(output valid, output in_byte, output last_byte, input ready);
	modport sink(input valid, input in_byte, input last_byte, output ready);
endinterface

// ===== design/utf8s_out_if.sv =====
// output channel: one sanitized result per transfer
interface utf8s_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       text_end;

	modport source(output valid, output out_byte, output byte_valid, output run_last,
		output text_end, input ready);
	modport sink(input valid, input out_byte, input byte_valid, input run_last,
		input text_end, output ready);
endinterface

// ===== design/utf8s_front.sv =====
// decoder front end: utf-8 state, code point filter and packing of output runs
module utf8s_front (
	input  logic              clk,
	input  logic              arst_n,
	utf8s_in_if.sink          in_ch,
	input  logic              q_full,
	output utf8s_pkg::qwr_t   q_wr
);

	logic [1:0]               cont_q;
	logic [20:0]              part_q;
	logic [1:0]               cont_d;
	logic [20:0]              part_d;
	logic                     acc;
	logic                     broken;
	logic                     trunc;
	logic                     do_filt;
	logic [20:0]              cp;
	utf8s_pkg::filt_t         f;
	logic [4:0]               cand_v;
	utf8s_pkg::byte_t [4:0]   cand_b;
	logic [2:0]               pos;
	utf8s_pkg::plan_t         plan;

	assign in_ch.ready = !q_full;
	assign acc = in_ch.valid && in_ch.ready;

	// sequence decode and next state
	always_comb begin
		cont_d  = cont_q;
		part_d  = part_q;
		broken  = 1'b0;
		do_filt = 1'b0;
		cp      = {13'd0, in_ch.in_byte};
		if (cont_q != 2'd0 && in_ch.in_byte[7:6] == 2'b10) begin
			part_d = {part_q[14:0], in_ch.in_byte[5:0]};
			cont_d = cont_q - 2'd1;
			if (cont_d == 2'd0) begin
				cp      = part_d;
				do_filt = 1'b1;
				part_d  = '0;
			end
		end else begin
			broken = (cont_q != 2'd0);
			cont_d = 2'd0;
			part_d = '0;
			if (!in_ch.in_byte[7]) begin
				do_filt = 1'b1;
			end else if (in_ch.in_byte[7:5] == 3'b110) begin
				part_d = {16'd0, in_ch.in_byte[4:0]};
				cont_d = 2'd1;
			end else if (in_ch.in_byte[7:4] == 4'b1110) begin
				part_d = {17'd0, in_ch.in_byte[3:0]};
				cont_d = 2'd2;
			end else if (in_ch.in_byte[7:3] == 5'b11110) begin
				part_d = {18'd0, in_ch.in_byte[2:0]};
				cont_d = 2'd3;
			end else begin
				cp      = utf8s_pkg::CP_REPLACE;
				do_filt = 1'b1;
			end
		end
		trunc = in_ch.last_byte && (cont_d != 2'd0);
		if (in_ch.last_byte) begin
			cont_d = 2'd0;
			part_d = '0;
		end
	end

	assign f = utf8s_pkg::filter_cp(cp);

	// pack broken-sequence mark, filtered bytes and truncation mark in order
	always_comb begin
		cand_v[0] = broken;
		cand_b[0] = utf8s_pkg::CH_QUEST;
		for (int i = 0; i < 3; i++) begin
			cand_v[i+1] = do_filt && (2'(i) < f.cnt);
			cand_b[i+1] = f.data[i];
		end
		cand_v[4] = trunc;
		cand_b[4] = utf8s_pkg::CH_QUEST;
		plan.data = '0;
		pos       = 3'd0;
		for (int i = 0; i < 5; i++) begin
			if (cand_v[i] && pos < 3'(utf8s_pkg::MAX_RUN)) begin
				plan.data[pos[1:0]] = cand_b[i];
				pos                 = pos + 3'd1;
			end
		end
		plan.cnt  = pos[1:0];
		plan.last = in_ch.last_byte;
	end

	// bytes that cause nothing and do not end the text leave no queue entry
	assign q_wr.push = acc && (pos != 3'd0 || in_ch.last_byte);
	assign q_wr.plan = plan;

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q <= 2'd0;
			part_q <= '0;
		end else if (acc) begin
			cont_q <= cont_d;
			part_q <= part_d;
		end
	end

`ifndef SYNTHESIS
	// the end of a text always leaves the decoder clean
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_ch.last_byte |=> cont_q == 2'd0 && part_q == '0)
		else $error("decoder state not cleared after end of text");
`endif

endmodule

// ===== design/utf8s_queue.sv =====
// short queue of output runs between the decoder and the serializer
module utf8s_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  utf8s_pkg::qwr_t  wr,
	input  logic             pop,
	output logic             full,
	output utf8s_pkg::qrd_t  rd
);

	utf8s_pkg::plan_t                    mem_q [utf8s_pkg::QDEPTH];
	logic [utf8s_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [utf8s_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [utf8s_pkg::QCNT_W-1:0]        count_q;

	assign full     = (count_q == utf8s_pkg::QCNT_W'(utf8s_pkg::QDEPTH));
	assign rd.avail = (count_q != '0);
	assign rd.plan  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.plan;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= (wr_ptr_q == utf8s_pkg::QPTR_W'(utf8s_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == utf8s_pkg::QPTR_W'(utf8s_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (wr.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!wr.push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> !full)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd.avail)
		else $error("pop from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= utf8s_pkg::QCNT_W'(utf8s_pkg::QDEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ===== design/utf8s_back.sv =====
// serializer: walks the head run byte by byte into the output register
module utf8s_back (
	input  logic             clk,
	input  logic             arst_n,
	input  utf8s_pkg::qrd_t  rd,
	output logic             pop,
	utf8s_out_if.source      out_ch
);

	utf8s_pkg::cnt_t   idx_q;
	logic              ovld_q;
	utf8s_pkg::res_t   res_q;
	utf8s_pkg::res_t   res_d;
	logic              load;
	logic              final_res;

	assign load = rd.avail && (!ovld_q || out_ch.ready);

	// result at the current position of the head run
	always_comb begin
		final_res = (rd.plan.cnt == 2'd0) || (idx_q == rd.plan.cnt - 2'd1);
		res_d.byte_valid = (rd.plan.cnt != 2'd0);
		res_d.out_byte   = res_d.byte_valid ? rd.plan.data[idx_q] : '0;
		res_d.run_last   = final_res;
		res_d.text_end   = final_res && rd.plan.last;
	end

	assign pop = load && final_res;

	// position in run and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 2'd0;
			ovld_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= final_res ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				ovld_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid      = ovld_q;
	assign out_ch.out_byte   = res_q.out_byte;
	assign out_ch.byte_valid = res_q.byte_valid;
	assign out_ch.run_last   = res_q.run_last;
	assign out_ch.text_end   = res_q.text_end;

endmodule

// ===== design/utf8_text_sanitizer_core.sv =====
// UTF-8 text sanitizer: takes one raw byte per transfer and gives the sanitized bytes of
// each input byte that causes any as a run of one to three results (a bare end marker
// where the last byte of a text gives none). A decoder accepts one byte per cycle while
// the queue is not full and pushes each run into a four-entry queue; a serializer sends
// one result per cycle while the receiver is ready, from the queue head through a
// registered output. Bytes that give one result or none go through at one per cycle when
// nothing stalls; a byte that gives several results holds the output until all are sent,
// and input stalls only once the queue is full. The first result of a byte is written into
// the queue and then into the output register. No clearing pass after reset.
module utf8_text_sanitizer_core (
	input  logic          clk,
	input  logic          arst_n,
	utf8s_in_if.sink      in_ch,
	utf8s_out_if.source   out_ch
);

	utf8s_pkg::qwr_t  q_wr;
	utf8s_pkg::qrd_t  q_rd;
	logic             q_full;
	logic             q_pop;

	// decode and filter
	utf8s_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	// run queue
	utf8s_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.rd     (q_rd)
	);

	// serialize runs to the output
	utf8s_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (q_rd),
		.pop    (q_pop),
		.out_ch (out_ch)
	);

`ifndef SYNTHESIS
	a_marker_ends_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.byte_valid |-> out_ch.text_end && out_ch.run_last)
		else $error("bare marker that does not end a text");
	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.text_end |-> out_ch.run_last)
		else $error("text end inside a run");
`endif

endmodule

// ===== tb/tb_utf8_text_sanitizer_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench for utf8_text_sanitizer_core: byte-stream prediction, scored results
module tb_utf8_text_sanitizer_core;

	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned DRAIN_TAIL  = 10;
	localparam int unsigned PHASE_ITEMS = 40;

	// code points on the borders of the filter classes
	localparam int unsigned N_EDGE_CPS = 40;
	localparam logic [20:0] EDGE_CPS [0:N_EDGE_CPS-1] = '{
		21'h09, 21'h0A, 21'h0D, 21'h1F, 21'h20, 21'h7E, 21'h7F, 21'h85, 21'h9F, 21'hA0,
		21'hFF, 21'h100, 21'h2002, 21'h2003, 21'h2009, 21'h202F, 21'h2010, 21'h2011,
		21'h2212, 21'h2013, 21'h2014, 21'h2018, 21'h201E, 21'h2022, 21'h2026, 21'h20AC,
		21'h200A, 21'h200B, 21'h200D, 21'h200E, 21'hFE00, 21'hFE0F, 21'hFE10, 21'h25FF,
		21'h2600, 21'h27BF, 21'h27C0, 21'hFFFD, 21'h1EFFF, 21'h1F000
	};

	// predicts the sanitized results of each accepted byte and scores what comes out
	class sanitized_stream_check;
		utf8s_pkg::res_t  pending_results[$];
		logic [1:0]       cont_left;
		logic [20:0]      cp_acc;
		utf8s_pkg::byte_t run_bytes[$];
		int unsigned      n_err;
		int unsigned      n_in;
		int unsigned      n_res;
		int unsigned      n_markers;
		int unsigned      n_texts;

		function new();
			cont_left = 2'd0;
			cp_acc    = '0;
			n_err     = 0;
			n_in      = 0;
			n_res     = 0;
			n_markers = 0;
			n_texts   = 0;
		endfunction

		task report(input string msg);
			n_err++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		function void put_byte(input utf8s_pkg::byte_t b);
			if (run_bytes.size() < 4)
				run_bytes.push_back(b);
		endfunction

		// keep, map or drop one decoded code point
		function void push_for_cp(input logic [20:0] cp);
			logic keep;
			logic gone;
			keep = (cp == 21'h0A) || (cp >= 21'h20 && cp <= 21'h7E) ||
				(cp >= 21'hA0 && cp <= 21'hFF) ||
				(cp inside {21'h2013, 21'h2014, [21'h2018:21'h201E], 21'h2022, 21'h2026,
				21'h20AC});
			gone = (cp < 21'h20) || (cp >= 21'h7F && cp < 21'hA0) || (cp >= 21'h1F000) ||
				(cp inside {[21'h200B:21'h200D], [21'hFE00:21'hFE0F], [21'h2600:21'h27BF]});
			if (keep) begin
				if (cp < 21'h80) begin
					put_byte(cp[7:0]);
				end else if (cp < 21'h800) begin
					put_byte({3'b110, cp[10:6]});
					put_byte({2'b10, cp[5:0]});
				end else begin
					put_byte({4'b1110, cp[15:12]});
					put_byte({2'b10, cp[11:6]});
					put_byte({2'b10, cp[5:0]});
				end
			end else if (cp inside {21'h09, 21'h2002, 21'h2003, 21'h2009, 21'h202F}) begin
				put_byte(utf8s_pkg::CH_SPACE);
			end else if (cp inside {21'h2010, 21'h2011, 21'h2212}) begin
				put_byte(utf8s_pkg::CH_HYPHEN);
			end else if (!gone) begin
				put_byte(utf8s_pkg::CH_QUEST);
			end
		endfunction

		// decode one accepted byte and queue the results it should cause
		function void take_byte(input utf8s_pkg::byte_t b, input logic last);
			logic            fresh;
			utf8s_pkg::res_t r;
			int              n;
			run_bytes.delete();
			fresh = 1'b1;
			n_in++;
			if (cont_left != 2'd0) begin
				if (b[7:6] == 2'b10) begin
					cp_acc    = {cp_acc[14:0], b[5:0]};
					cont_left = cont_left - 2'd1;
					if (cont_left == 2'd0) begin
						push_for_cp(cp_acc);
						cp_acc = '0;
					end
					fresh = 1'b0;
				end else begin
					// broken sequence: replacement, then the byte starts over
					push_for_cp(utf8s_pkg::CP_REPLACE);
					cont_left = 2'd0;
					cp_acc    = '0;
				end
			end
			if (fresh) begin
				casez (b)
					8'b0???????: push_for_cp({13'd0, b});
					8'b110?????: begin
						cp_acc    = {16'd0, b[4:0]};
						cont_left = 2'd1;
					end
					8'b1110????: begin
						cp_acc    = {17'd0, b[3:0]};
						cont_left = 2'd2;
					end
					8'b11110???: begin
						cp_acc    = {18'd0, b[2:0]};
						cont_left = 2'd3;
					end
					default: push_for_cp(utf8s_pkg::CP_REPLACE);
				endcase
			end
			// end of text closes any open sequence
			if (last) begin
				if (cont_left != 2'd0)
					push_for_cp(utf8s_pkg::CP_REPLACE);
				cont_left = 2'd0;
				cp_acc    = '0;
			end
			n = (run_bytes.size() > int'(utf8s_pkg::MAX_RUN)) ? int'(utf8s_pkg::MAX_RUN) :
				run_bytes.size();
			if (n == 0 && last) begin
				r.out_byte   = 8'h00;
				r.byte_valid = 1'b0;
				r.run_last   = 1'b1;
				r.text_end   = 1'b1;
				pending_results.push_back(r);
			end
			for (int k = 0; k < n; k++) begin
				r.out_byte   = run_bytes[k];
				r.byte_valid = 1'b1;
				r.run_last   = (k == n - 1);
				r.text_end   = last && (k == n - 1);
				pending_results.push_back(r);
			end
		endfunction

		// score one result transfer against the oldest prediction
		task match_result(input utf8s_pkg::res_t got);
			utf8s_pkg::res_t want;
			n_res++;
			if (got.text_end)
				n_texts++;
			if (!got.byte_valid)
				n_markers++;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result byte %02h valid %0b run_last %0b end %0b",
					got.out_byte, got.byte_valid, got.run_last, got.text_end));
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					report($sformatf("result %0d: got %02h/%0b/%0b/%0b want %02h/%0b/%0b/%0b",
						n_res, got.out_byte, got.byte_valid, got.run_last, got.text_end,
						want.out_byte, want.byte_valid, want.run_last, want.text_end));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	utf8s_in_if  in_ch();
	utf8s_out_if out_ch();

	sanitized_stream_check chk;
	utf8s_pkg::byte_t chunk_q[$];
	int unsigned      src_idle_pct;
	int unsigned      snk_stall_pct;
	int unsigned      hold_left;
	int unsigned      items_sent;

	utf8_text_sanitizer_core u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	// note each input transfer before scoring result transfers of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				chk.take_byte(in_ch.in_byte, in_ch.last_byte);
			if (out_ch.valid && out_ch.ready)
				chk.match_result({out_ch.out_byte, out_ch.byte_valid, out_ch.run_last,
					out_ch.text_end});
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles", QUIET_LIMIT);
		$display("[utf8_text_sanitizer_core] ERROR");
		$finish;
	end

	// offer one byte, with random idle cycles first, until it is taken
	task automatic send_byte(input utf8s_pkg::byte_t b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.in_byte   <= b;
		in_ch.last_byte <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		items_sent++;
	endtask

	// stop offering until every predicted result has arrived
	task automatic pause_until_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (chk.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// utf-8 bytes of a code point in a chosen length, overlong forms allowed
	function automatic void push_utf8(input logic [20:0] cp, input int unsigned len);
		case (len)
			1: chunk_q.push_back({1'b0, cp[6:0]});
			2: begin
				chunk_q.push_back({3'b110, cp[10:6]});
				chunk_q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				chunk_q.push_back({4'b1110, cp[15:12]});
				chunk_q.push_back({2'b10, cp[11:6]});
				chunk_q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				chunk_q.push_back({5'b11110, cp[20:18]});
				chunk_q.push_back({2'b10, cp[17:12]});
				chunk_q.push_back({2'b10, cp[11:6]});
				chunk_q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic int unsigned utf8_len(input logic [20:0] cp);
		if (cp < 21'h80)
			return 1;
		else if (cp < 21'h800)
			return 2;
		else if (cp < 21'h10000)
			return 3;
		return 4;
	endfunction

	// one random piece of text in chunk_q; returns 1 when it must end the text
	function automatic logic make_chunk();
		int unsigned      kind;
		int unsigned      len;
		int unsigned      keep_n;
		logic [20:0]      cp;
		utf8s_pkg::byte_t b;
		chunk_q.delete();
		kind = $urandom_range(99);
		if (kind < 25) begin
			chunk_q.push_back(utf8s_pkg::byte_t'($urandom_range(127)));
		end else if (kind < 47) begin
			cp = EDGE_CPS[$urandom_range(N_EDGE_CPS - 1)];
			push_utf8(cp, utf8_len(cp));
		end else if (kind < 77) begin
			len = $urandom_range(2, 4);
			cp  = 21'($urandom_range((1 << (len * 5 + 1)) - 1));
			push_utf8(cp, len);
		end else if (kind < 87) begin
			chunk_q.push_back(utf8s_pkg::byte_t'($urandom_range(255)));
		end else begin
			// open a sequence and cut it short
			len = $urandom_range(2, 4);
			push_utf8(21'($urandom_range(21'h1FFFFF)), len);
			keep_n = $urandom_range(1, len - 1);
			while (chunk_q.size() > keep_n)
				void'(chunk_q.pop_back());
			if (kind < 95) begin
				b = utf8s_pkg::byte_t'($urandom_range(255));
				if (b[7:6] == 2'b10)
					b[7:6] = {b[0], 1'b1};
				chunk_q.push_back(b);
			end else begin
				return 1'b1;
			end
		end
		return ($urandom_range(9) == 0);
	endfunction

	task automatic run_random(input int unsigned n_items);
		int unsigned start;
		logic        last;
		start = items_sent;
		while (items_sent - start < n_items) begin
			last = make_chunk();
			foreach (chunk_q[i])
				send_byte(chunk_q[i], last && (i == chunk_q.size() - 1));
		end
	endtask

	// extremes and special cases of the decoder and the filter
	task automatic run_directed();
		send_byte(8'h41, 1'b0);
		send_byte(8'h0A, 1'b0);
		// tab maps to a space, nul is dropped
		send_byte(8'h09, 1'b0);
		send_byte(8'h00, 1'b0);
		// bad leads: stray continuation and 0xf8 / 0xff
		send_byte(8'h80, 1'b0);
		send_byte(8'hF8, 1'b0);
		send_byte(8'hFF, 1'b0);
		// overlong nul through a 0xc0 lead, then dropped
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
		// euro sign gives a full run of three
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		// minus sign becomes a hyphen
		send_byte(8'hE2, 1'b0);
		send_byte(8'h88, 1'b0);
		send_byte(8'h92, 1'b0);
		// emoji dropped
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b0);
		// broken sequence, the breaking byte decoded afresh
		send_byte(8'hE2, 1'b0);
		send_byte(8'h41, 1'b0);
		// truncated at end of text, then a text ending in a dropped byte
		send_byte(8'hC3, 1'b1);
		send_byte(8'h7F, 1'b1);
	endtask

	// stimulus and final verdict
	initial begin
		chk           = new();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_left     = 0;
		items_sent    = 0;
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.in_byte   <= 8'h00;
		in_ch.last_byte <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no idling, then a long receiver hold-off while bytes keep coming
		run_directed();
		hold_left = HOLD_CYCLES;
		run_random(PHASE_ITEMS);
		pause_until_drained();

		// sender mostly idle, with a full drain in the middle
		src_idle_pct = 85;
		run_random(PHASE_ITEMS / 2);
		pause_until_drained();
		run_random(PHASE_ITEMS / 2);
		pause_until_drained();

		// receiver mostly stalled
		src_idle_pct  = 0;
		snk_stall_pct = 85;
		run_random(PHASE_ITEMS);
		pause_until_drained();

		// both sides idling
		src_idle_pct  = 28;
		snk_stall_pct = 28;
		run_random(PHASE_ITEMS);
		pause_until_drained();
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("covered %0d input bytes and %0d results, %0d texts ended, %0d bare markers",
			chk.n_in, chk.n_res, chk.n_texts, chk.n_markers);
		$display("phases: free-running, receiver hold-off, sender idle, receiver stall, mixed");
		if (chk.n_err == 0 && chk.pending_results.size() == 0) begin
			$display("[utf8_text_sanitizer_core] OK");
		end else begin
			$display("%0d mismatches, %0d results still due", chk.n_err,
				chk.pending_results.size());
			$display("[utf8_text_sanitizer_core] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/utf8s_pkg.sv
design/utf8s_in_if.sv
design/utf8s_out_if.sv
design/utf8s_front.sv
design/utf8s_queue.sv
design/utf8s_back.sv
design/utf8_text_sanitizer_core.sv
tb/tb_utf8_text_sanitizer_core.sv
